FILE: sv/sgdm_pkg.sv
package sgdm_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int RND_HALF  = 1 << (FRAC_W - 1);

    // datapath widths
    localparam int L2P_W     = COEF_W + 1 + DATA_W;
    localparam int SUM_W     = DATA_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int PROD_W    = COEF_W + 1 + SUM_W;
    localparam int STEP_W    = PROD_W - FRAC_W;
    localparam int MPROD_W   = COEF_W + 1 + DATA_W;
    localparam int DX_W      = STEP_W + 2;

    // pipeline registers from accept to output register
    localparam int LATENCY      = DIV_STEPS + 7;
    localparam int INFLIGHT_MAX = LATENCY + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_DECAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LRATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE = 3'd4;

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] new_weight;
        logic                     saturated;
    } t_out_item;

    function automatic logic [ADDR_W-1:0] vel_addr(logic [IDX_W-1:0] idx);
        logic [31:0] e;
        e = 32'(idx);
        return ADDR_W'(e % DEPTH);
    endfunction

endpackage

FILE: sv/sgdm_in_if.sv
interface sgdm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [sgdm_pkg::IDX_W-1:0]     weight_index;
    logic signed [sgdm_pkg::DATA_W-1:0]    weight_value;
    logic signed [sgdm_pkg::DATA_W-1:0]    gradient_value;

    modport source (output valid, output weight_index, output weight_value,
                    output gradient_value, input ready);
    modport sink   (input valid, input weight_index, input weight_value,
                    input gradient_value, output ready);
endinterface

FILE: sv/sgdm_out_if.sv
interface sgdm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sgdm_pkg::DATA_W-1:0]    new_weight;
    logic                                  saturated;

    modport source (output valid, output new_weight, output saturated, input ready);
    modport sink   (input valid, input new_weight, input saturated, output ready);
endinterface

FILE: sv/sgdm_ram.sv
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/sgd_momentum_weight_update.sv
// SGD weight update with momentum and L1/L2 decay, Q16.16 weights and gradients,
// Q0.16 coefficients. One item is accepted per clock, held by the single-cycle
// velocity read-modify-write loop (one 17x32 multiply, subtract and clamp with
// write-back forwarding), while the skid entry is empty. The updated weight
// passes through the 33-step restoring divider that applies the batch size.
// After reset the velocity memory is cleared entry by entry; input ready
// stays low until it finishes. Configuration writes are taken at any time but
// must only happen while no item is in flight.
module sgd_momentum_weight_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgdm_pkg::COEF_W-1:0]       i_cfg_data,
    sgdm_in_if.sink                           i_in,
    sgdm_out_if.source                        o_out
);

    typedef struct packed {
        logic [sgdm_pkg::COEF_W-1:0]        rem;
        logic [sgdm_pkg::MAG_W-1:0]         num;
        logic                               neg;
        logic [sgdm_pkg::ADDR_W-1:0]        idx;
        logic signed [sgdm_pkg::DATA_W-1:0] w;
    } t_dstg;

    function automatic t_dstg div_step(t_dstg s, logic [sgdm_pkg::COEF_W-1:0] d);
        t_dstg                       o;
        logic [sgdm_pkg::COEF_W:0]   t;
        logic [sgdm_pkg::COEF_W:0]   diff;
        o    = s;
        t    = {s.rem, s.num[sgdm_pkg::MAG_W-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            o.rem = diff[sgdm_pkg::COEF_W-1:0];
            o.num = {s.num[sgdm_pkg::MAG_W-2:0], 1'b1};
        end else begin
            o.rem = t[sgdm_pkg::COEF_W-1:0];
            o.num = {s.num[sgdm_pkg::MAG_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // {flag, value}
    function automatic logic [sgdm_pkg::DATA_W:0] clamp32(
        logic signed [sgdm_pkg::DX_W-1:0] v);
        if (v > sgdm_pkg::DX_W'(sgdm_pkg::S_MAX)) begin
            return {1'b1, sgdm_pkg::S_MAX};
        end else if (v < sgdm_pkg::DX_W'(sgdm_pkg::S_MIN)) begin
            return {1'b1, sgdm_pkg::S_MIN};
        end else begin
            return {1'b0, v[sgdm_pkg::DATA_W-1:0]};
        end
    endfunction

    // configuration
    logic [sgdm_pkg::COEF_W-1:0] r_l1;
    logic [sgdm_pkg::COEF_W-1:0] r_l2;
    logic [sgdm_pkg::COEF_W-1:0] r_lr;
    logic [sgdm_pkg::COEF_W-1:0] r_mom;
    logic [sgdm_pkg::COEF_W-1:0] r_batch;
    logic [sgdm_pkg::COEF_W-1:0] div_eff;
    logic                        mom_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1    <= '0;
            r_l2    <= '0;
            r_lr    <= '0;
            r_mom   <= '0;
            r_batch <= sgdm_pkg::COEF_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgdm_pkg::CFG_L1_DECAY:   r_l1    <= i_cfg_data;
                sgdm_pkg::CFG_L2_DECAY:   r_l2    <= i_cfg_data;
                sgdm_pkg::CFG_LRATE:      r_lr    <= i_cfg_data;
                sgdm_pkg::CFG_MOMENTUM:   r_mom   <= i_cfg_data;
                sgdm_pkg::CFG_BATCH_SIZE: r_batch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign div_eff = (r_batch == '0) ? sgdm_pkg::COEF_W'(1) : r_batch;
    assign mom_on  = (r_mom != '0);

    // velocity clear after reset
    logic [sgdm_pkg::ADDR_W:0] r_clr_cnt;
    logic                      clr_busy;

    assign clr_busy = !r_clr_cnt[sgdm_pkg::ADDR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // flow control
    logic r_skd_v;
    logic adv;
    logic accept;

    assign adv        = !r_skd_v;
    assign i_in.ready = adv && !clr_busy;
    assign accept     = i_in.valid && i_in.ready;

    // pipeline registers
    logic                                 r_a_v;
    logic [sgdm_pkg::ADDR_W-1:0]          r_a_idx;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_a_w;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_a_g;

    logic                                 r_b_v;
    logic [sgdm_pkg::ADDR_W-1:0]          r_b_idx;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_b_w;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_b_g;
    logic signed [sgdm_pkg::L2P_W-1:0]    r_b_l2p;

    logic                                 r_d_v [sgdm_pkg::DIV_STEPS+1];
    t_dstg                                r_d   [sgdm_pkg::DIV_STEPS+1];

    logic                                 r_e_v;
    logic [sgdm_pkg::ADDR_W-1:0]          r_e_idx;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_e_w;
    logic signed [sgdm_pkg::SUM_W-1:0]    r_e_grad;

    logic                                 r_f_v;
    logic [sgdm_pkg::ADDR_W-1:0]          r_f_idx;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_f_w;
    logic signed [sgdm_pkg::PROD_W-1:0]   r_f_prod;

    logic                                 r_g_v;
    logic [sgdm_pkg::ADDR_W-1:0]          r_g_idx;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_g_w;
    logic signed [sgdm_pkg::STEP_W-1:0]   r_g_step;
    logic                                 r_fwd_hit;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_fwd_vel;

    logic                                 r_h_v;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_h_w;
    logic signed [sgdm_pkg::DATA_W-1:0]   r_h_dx;
    logic                                 r_h_vsat;
    logic signed [sgdm_pkg::STEP_W-1:0]   r_h_step;

    // stage B -> D0: gradient sum, sign/magnitude split
    logic signed [sgdm_pkg::L2P_W-1:0]    l2_rnd;
    logic signed [sgdm_pkg::SUM_W-1:0]    l1_t;
    logic signed [sgdm_pkg::SUM_W-1:0]    gsum;
    logic signed [sgdm_pkg::SUM_W-1:0]    gsum_abs;
    t_dstg                                d_init;

    assign l2_rnd   = (r_b_l2p + $signed(sgdm_pkg::L2P_W'(sgdm_pkg::RND_HALF)))
                      >>> sgdm_pkg::FRAC_W;
    assign l1_t     = (r_b_w > 0) ? $signed(sgdm_pkg::SUM_W'(r_l1))
                                  : -$signed(sgdm_pkg::SUM_W'(r_l1));
    assign gsum     = l1_t + sgdm_pkg::SUM_W'(l2_rnd) + sgdm_pkg::SUM_W'(r_b_g);
    assign gsum_abs = gsum[sgdm_pkg::SUM_W-1] ? -gsum : gsum;

    always_comb begin
        d_init     = '0;
        d_init.num = gsum_abs[sgdm_pkg::MAG_W-1:0];
        d_init.neg = gsum[sgdm_pkg::SUM_W-1];
        d_init.idx = r_b_idx;
        d_init.w   = r_b_w;
    end

    // stage D end -> E: signed quotient
    logic signed [sgdm_pkg::SUM_W-1:0] quot;

    assign quot = $signed({1'b0, r_d[sgdm_pkg::DIV_STEPS].num});

    // stage G: velocity update
    logic [sgdm_pkg::DATA_W-1:0]          ram_rdata;
    logic signed [sgdm_pkg::DATA_W-1:0]   vel;
    logic signed [sgdm_pkg::MPROD_W-1:0]  mprod;
    logic signed [sgdm_pkg::MPROD_W-1:0]  mrnd;
    logic signed [sgdm_pkg::DX_W-1:0]     dx_raw;
    logic [sgdm_pkg::DATA_W:0]            dx_c;
    logic signed [sgdm_pkg::STEP_W-1:0]   step_f;
    logic signed [sgdm_pkg::PROD_W-1:0]   prod_rnd;
    logic                                 vel_we;

    assign prod_rnd = (r_f_prod + $signed(sgdm_pkg::PROD_W'(sgdm_pkg::RND_HALF)))
                      >>> sgdm_pkg::FRAC_W;
    assign step_f   = sgdm_pkg::STEP_W'(prod_rnd);

    assign vel    = r_fwd_hit ? r_fwd_vel : $signed(ram_rdata);
    assign mprod  = sgdm_pkg::MPROD_W'($signed({1'b0, r_mom}))
                    * sgdm_pkg::MPROD_W'(vel);
    assign mrnd   = (mprod + $signed(sgdm_pkg::MPROD_W'(sgdm_pkg::RND_HALF)))
                    >>> sgdm_pkg::FRAC_W;
    assign dx_raw = sgdm_pkg::DX_W'(mrnd) - sgdm_pkg::DX_W'(r_g_step);
    assign dx_c   = clamp32(dx_raw);
    assign vel_we = r_g_v && adv && mom_on;

    sgdm_ram #(
        .WIDTH (sgdm_pkg::DATA_W),
        .DEPTH (sgdm_pkg::DEPTH)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (clr_busy || vel_we),
        .i_waddr (clr_busy ? r_clr_cnt[sgdm_pkg::ADDR_W-1:0] : r_g_idx),
        .i_wdata (clr_busy ? '0 : dx_c[sgdm_pkg::DATA_W-1:0]),
        .i_re    (adv),
        .i_raddr (r_f_idx),
        .o_rdata (ram_rdata)
    );

    // stage H: new weight
    logic signed [sgdm_pkg::DX_W-1:0] nw_raw;
    logic [sgdm_pkg::DATA_W:0]        nw_c;
    logic                             push;
    sgdm_pkg::t_out_item              push_item;

    assign nw_raw = mom_on ? sgdm_pkg::DX_W'(r_h_w) + sgdm_pkg::DX_W'(r_h_dx)
                           : sgdm_pkg::DX_W'(r_h_w) - sgdm_pkg::DX_W'(r_h_step);
    assign nw_c   = clamp32(nw_raw);
    assign push   = adv && r_h_v;

    always_comb begin
        push_item.new_weight = nw_c[sgdm_pkg::DATA_W-1:0];
        push_item.saturated  = nw_c[sgdm_pkg::DATA_W] || (mom_on && r_h_vsat);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            for (int k = 0; k <= sgdm_pkg::DIV_STEPS; k++) begin
                r_d_v[k] <= 1'b0;
            end
            r_e_v     <= 1'b0;
            r_f_v     <= 1'b0;
            r_g_v     <= 1'b0;
            r_h_v     <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (adv) begin
            r_a_v    <= accept;
            r_b_v    <= r_a_v;
            r_d_v[0] <= r_b_v;
            for (int k = 1; k <= sgdm_pkg::DIV_STEPS; k++) begin
                r_d_v[k] <= r_d_v[k-1];
            end
            r_e_v     <= r_d_v[sgdm_pkg::DIV_STEPS];
            r_f_v     <= r_e_v;
            r_g_v     <= r_f_v;
            r_h_v     <= r_g_v;
            r_fwd_hit <= r_g_v && mom_on && (r_g_idx == r_f_idx);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_idx <= sgdm_pkg::vel_addr(i_in.weight_index);
            r_a_w   <= i_in.weight_value;
            r_a_g   <= i_in.gradient_value;

            r_b_idx <= r_a_idx;
            r_b_w   <= r_a_w;
            r_b_g   <= r_a_g;
            r_b_l2p <= sgdm_pkg::L2P_W'($signed({1'b0, r_l2}))
                       * sgdm_pkg::L2P_W'(r_a_w);

            r_d[0] <= d_init;
            for (int k = 1; k <= sgdm_pkg::DIV_STEPS; k++) begin
                r_d[k] <= div_step(r_d[k-1], div_eff);
            end

            r_e_idx  <= r_d[sgdm_pkg::DIV_STEPS].idx;
            r_e_w    <= r_d[sgdm_pkg::DIV_STEPS].w;
            r_e_grad <= r_d[sgdm_pkg::DIV_STEPS].neg ? -quot : quot;

            r_f_idx  <= r_e_idx;
            r_f_w    <= r_e_w;
            r_f_prod <= sgdm_pkg::PROD_W'($signed({1'b0, r_lr}))
                        * sgdm_pkg::PROD_W'(r_e_grad);

            r_g_idx  <= r_f_idx;
            r_g_w    <= r_f_w;
            r_g_step <= step_f;
            r_fwd_vel <= dx_c[sgdm_pkg::DATA_W-1:0];

            r_h_w    <= r_g_w;
            r_h_dx   <= dx_c[sgdm_pkg::DATA_W-1:0];
            r_h_vsat <= dx_c[sgdm_pkg::DATA_W];
            r_h_step <= r_g_step;
        end
    end

    // output register plus skid entry
    logic                r_out_v;
    sgdm_pkg::t_out_item r_out;
    sgdm_pkg::t_out_item r_skd;
    logic                pop;

    assign pop = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            r_out_v <= r_skd_v || push;
            r_skd_v <= 1'b0;
        end else if (push) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out <= r_skd_v ? r_skd : push_item;
        end
        if (push && r_out_v && !pop) begin
            r_skd <= push_item;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.new_weight = r_out.new_weight;
    assign o_out.saturated  = r_out.saturated;

endmodule

FILE: sv/sgdm_checker.sv
module sgdm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [sgdm_pkg::DATA_W-1:0] i_out_weight,
    input logic                              i_out_sat
);

    localparam int CNT_W = $clog2(sgdm_pkg::INFLIGHT_MAX + 1) + 1;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign n_cnt = r_cnt + CNT_W'(i_in_valid && i_in_ready)
                         - CNT_W'(i_out_valid && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // velocity clear holds off input right after reset
    a_clear_holds_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during velocity clear");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without a pending item");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(sgdm_pkg::INFLIGHT_MAX))
        else $error("more items in flight than pipeline holds");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_weight) && $stable(i_out_sat))
        else $error("stalled result changed");

endmodule

bind sgd_momentum_weight_update sgdm_checker u_sgdm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_weight (o_out.new_weight),
    .i_out_sat    (o_out.saturated)
);

FILE: bench/tb_sgd_momentum_weight_update.sv
`timescale 1ns / 1ps

class weight_update_tracker;
    longint                             l1_decay;
    longint                             l2_decay;
    longint                             learning_rate;
    longint                             momentum_factor;
    longint                             batch_size;
    logic signed [sgdm_pkg::DATA_W-1:0] velocity [sgdm_pkg::DEPTH];
    sgdm_pkg::t_out_item                expected_updates [$];
    int                                 failures;

    function new();
        l1_decay        = 0;
        l2_decay        = 0;
        learning_rate   = 0;
        momentum_factor = 0;
        batch_size      = 1;
        failures        = 0;
        foreach (velocity[i]) velocity[i] = '0;
    endfunction

    function void set_reg(logic [sgdm_pkg::CFG_IDX_W-1:0] idx,
                          logic [sgdm_pkg::COEF_W-1:0] data);
        case (idx)
            sgdm_pkg::CFG_L1_DECAY:   l1_decay        = data;
            sgdm_pkg::CFG_L2_DECAY:   l2_decay        = data;
            sgdm_pkg::CFG_LRATE:      learning_rate   = data;
            sgdm_pkg::CFG_MOMENTUM:   momentum_factor = data;
            sgdm_pkg::CFG_BATCH_SIZE: batch_size      = data;
            default: ;
        endcase
    endfunction

    // round to nearest, ties toward +inf
    function longint round_q16(longint v);
        return (v + longint'(sgdm_pkg::RND_HALF)) >>> sgdm_pkg::FRAC_W;
    endfunction

    function longint clamp_q16(longint v, inout bit sat);
        if (v > longint'(sgdm_pkg::S_MAX)) begin
            sat = 1'b1;
            return longint'(sgdm_pkg::S_MAX);
        end
        if (v < longint'(sgdm_pkg::S_MIN)) begin
            sat = 1'b1;
            return longint'(sgdm_pkg::S_MIN);
        end
        return v;
    endfunction

    function void predict_update(logic [sgdm_pkg::IDX_W-1:0] idx,
                                 logic signed [sgdm_pkg::DATA_W-1:0] w,
                                 logic signed [sgdm_pkg::DATA_W-1:0] g);
        longint              wl, gl, div, l1t, l2t, grad, step, dx, nw;
        int                  slot;
        bit                  sat;
        sgdm_pkg::t_out_item e;
        wl   = w;
        gl   = g;
        sat  = 1'b0;
        div  = (batch_size == 0) ? 1 : batch_size;
        l1t  = (wl > 0) ? l1_decay : -l1_decay;
        l2t  = round_q16(l2_decay * wl);
        grad = (l1t + l2t + gl) / div;
        step = round_q16(learning_rate * grad);
        if (momentum_factor != 0) begin
            slot = int'(idx) % sgdm_pkg::DEPTH;
            dx = round_q16(momentum_factor * longint'(velocity[slot])) - step;
            dx = clamp_q16(dx, sat);
            velocity[slot] = sgdm_pkg::DATA_W'(dx);
            nw = clamp_q16(wl + dx, sat);
        end else begin
            nw = clamp_q16(wl - step, sat);
        end
        e.new_weight = sgdm_pkg::DATA_W'(nw);
        e.saturated  = sat;
        expected_updates.push_back(e);
    endfunction

    function void check_update(logic signed [sgdm_pkg::DATA_W-1:0] nw, logic sat);
        sgdm_pkg::t_out_item e;
        if (expected_updates.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected item new_weight=%h saturated=%b", $time, nw, sat);
            return;
        end
        e = expected_updates.pop_front();
        if (nw !== e.new_weight || sat !== e.saturated) begin
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch new_weight exp %h got %h, saturated exp %b got %b",
                         $time, e.new_weight, nw, e.saturated, sat);
        end
    endfunction

    function int pending();
        return expected_updates.size();
    endfunction
endclass

module tb_sgd_momentum_weight_update;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 55;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [sgdm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sgdm_pkg::COEF_W-1:0]    i_cfg_data;

    sgdm_in_if  in_if ();
    sgdm_out_if out_if ();

    sgd_momentum_weight_update dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    weight_update_tracker tracker;
    int unsigned          src_idle_pct;
    int unsigned          snk_stall_pct;
    int unsigned          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_sgd_momentum_weight_update: FAIL");
            $finish;
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            tracker.check_update(out_if.new_weight, out_if.saturated);
    end

    task automatic write_reg(input logic [sgdm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgdm_pkg::COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [sgdm_pkg::COEF_W-1:0] l1,
                                input logic [sgdm_pkg::COEF_W-1:0] l2,
                                input logic [sgdm_pkg::COEF_W-1:0] lr,
                                input logic [sgdm_pkg::COEF_W-1:0] mom,
                                input logic [sgdm_pkg::COEF_W-1:0] bs);
        write_reg(sgdm_pkg::CFG_L1_DECAY, l1);
        write_reg(sgdm_pkg::CFG_L2_DECAY, l2);
        write_reg(sgdm_pkg::CFG_LRATE, lr);
        write_reg(sgdm_pkg::CFG_MOMENTUM, mom);
        write_reg(sgdm_pkg::CFG_BATCH_SIZE, bs);
        // indexes past the last register must be ignored
        write_reg(sgdm_pkg::CFG_IDX_W'($urandom_range(2**sgdm_pkg::CFG_IDX_W - 1,
                                                      int'(sgdm_pkg::CFG_BATCH_SIZE) + 1)),
                  sgdm_pkg::COEF_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic [sgdm_pkg::IDX_W-1:0] idx,
                             input logic signed [sgdm_pkg::DATA_W-1:0] w,
                             input logic signed [sgdm_pkg::DATA_W-1:0] g);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.weight_index   <= idx;
        in_if.weight_value   <= w;
        in_if.gradient_value <= g;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.predict_update(idx, w, g);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [sgdm_pkg::DATA_W-1:0] rand_value();
        int v;
        case ($urandom_range(9))
            0: v = sgdm_pkg::S_MAX;
            1: v = sgdm_pkg::S_MIN;
            2: v = int'($urandom_range(3)) - 1;
            3, 4, 5: v = int'($urandom_range(1 << 21)) - (1 << 20);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [sgdm_pkg::IDX_W-1:0] rand_index();
        if ($urandom_range(9) < 6)
            return sgdm_pkg::IDX_W'($urandom_range(7));
        return sgdm_pkg::IDX_W'($urandom_range(2**sgdm_pkg::IDX_W - 1));
    endfunction

    function automatic logic [sgdm_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return sgdm_pkg::COEF_W'($urandom_range(4095));
            default: return sgdm_pkg::COEF_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [sgdm_pkg::COEF_W-1:0] mom, bs;
        tracker              = new();
        cycle_count          = 0;
        src_idle_pct         = 0;
        snk_stall_pct        = 0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.weight_index   = '0;
        in_if.weight_value   = '0;
        in_if.gradient_value = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all coefficients at full scale, momentum on
        apply_config('1, '1, '1, '1, 16'd1);
        push_item('0, sgdm_pkg::S_MAX, sgdm_pkg::S_MAX);
        push_item('0, sgdm_pkg::S_MIN, sgdm_pkg::S_MIN);
        push_item('1, 32'sd0, 32'sd0);
        push_item(10'd1, 32'sd1, -32'sd1);
        push_item('0, -32'sd1, sgdm_pkg::S_MAX);
        push_item('0, 32'sd65536, sgdm_pkg::S_MIN);
        push_item(10'd1, sgdm_pkg::S_MAX, 32'sd0);
        drain();

        // plain SGD, zero batch size
        apply_config('1, '1, '1, '0, '0);
        push_item('0, sgdm_pkg::S_MAX, sgdm_pkg::S_MIN);
        push_item('1, sgdm_pkg::S_MIN, sgdm_pkg::S_MAX);
        push_item(10'd2, 32'sd0, 32'sd0);
        push_item(10'd3, 32'sd1, 32'sd1);
        push_item(10'd4, -32'sd1, -32'sd1);
        push_item('0, 32'sd0, sgdm_pkg::S_MAX);
        drain();

        // smallest momentum and rate, largest batch
        apply_config(16'd1, 16'd1, 16'd1, 16'd1, '1);
        push_item('0, sgdm_pkg::S_MIN, sgdm_pkg::S_MIN);
        push_item(10'd512, sgdm_pkg::S_MAX, sgdm_pkg::S_MAX);
        push_item('1, 32'sd0, -32'sd65536);
        push_item(10'd1, -32'sd1, 32'sd0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_config('1, '1, '1, '1, 16'd1);
                1: apply_config('0, '0, '1, '0, 16'd1);
                2: apply_config(rand_coef(), rand_coef(), rand_coef(), '0, '0);
                3: apply_config('0, '0, '0, '1, 16'd1);
                4: apply_config(rand_coef(), rand_coef(), rand_coef(), rand_coef(), '1);
                default: begin
                    mom = ($urandom_range(2) == 0) ? '0 : rand_coef();
                    bs  = ($urandom_range(3) == 0) ? sgdm_pkg::COEF_W'($urandom)
                                                   : sgdm_pkg::COEF_W'($urandom_range(8));
                    apply_config(rand_coef(), rand_coef(), rand_coef(), mom, bs);
                end
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
                default: begin src_idle_pct = 27; snk_stall_pct = 27; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2)
                    drain();
                push_item(rand_index(), rand_value(), rand_value());
            end
            drain();
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (2 * sgdm_pkg::LATENCY) @(negedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("tb_sgd_momentum_weight_update: PASS");
        else
            $display("tb_sgd_momentum_weight_update: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sgdm_pkg.sv
sv/sgdm_in_if.sv
sv/sgdm_out_if.sv
sv/sgdm_ram.sv
sv/sgd_momentum_weight_update.sv
sv/sgdm_checker.sv
bench/tb_sgd_momentum_weight_update.sv
